>>> hw/rtl/crtd_pkg.sv
package crtd_pkg;

  localparam int CODE_W = 8;
  localparam int COL_W  = 10;
  localparam int OUT_ROW_W = 6;
  localparam int TILE_W = 8;
  localparam int CFG_W  = 11;
  localparam int CNT_W  = 7;

  // column count limit of the map
  localparam logic [CFG_W-1:0] MAX_COLUMNS = 11'd1024;

  typedef logic [1:0] mode_t;

  localparam mode_t MODE_LITERAL = 2'd0;
  localparam mode_t MODE_SHORT   = 2'd1;
  localparam mode_t MODE_ZEROS   = 2'd2;
  localparam mode_t MODE_SINGLE  = 2'd3;

endpackage

>>> hw/rtl/column_rle_tile_decoder.sv
// Column run-length tile decoder.
// Input stream (s_*): one code byte per item in s_tdata, new_map in s_tuser.
// A code byte expands into 0 to 64 tile writes, filling columns of
// COLUMN_HEIGHT cells top to bottom, column by column.
// Output stream (m_*): one tile write per item; m_tlast marks the last write
// caused by a byte, m_tuser marks the write of the last cell of the map.
// Config channel (cfg_*): sets map_columns; write it only while the block is idle.
// Timing: a byte is taken when s_tready is high. A byte with writes then
// holds s_tready low while the writes leave at one per cycle as long as
// m_tready is high; a mode 0 header, an empty run or an ignored byte leaves
// s_tready high. The row and column stepper handles one write per cycle
// while m_tready is high. The first write is visible the cycle after the
// byte is accepted.
// A stalled m_tready freezes the write in place; nothing is lost or repeated.
// Reset clears position, pending literal and done state and sets
// map_columns to 1. After the last column, bytes are taken and dropped
// until a byte arrives with new_map set.
module column_rle_tile_decoder
  import crtd_pkg::*;
#(
  parameter int COLUMN_HEIGHT = 64
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,    // [7:0] code_byte
  input  logic        s_tuser,    // [0] new_map
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [23:0] m_tdata,    // [9:0] column, [15:10] row, [23:16] tile
  output logic        m_tlast,    // last_of_run
  output logic        m_tuser,    // [0] map_complete
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [10:0] cfg_data    // map_columns
);

  localparam int ROW_W = (COLUMN_HEIGHT > 2) ? $clog2(COLUMN_HEIGHT) : 1;
  localparam logic [ROW_W-1:0] LAST_ROW = ROW_W'(COLUMN_HEIGHT - 1);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_RUN  = 1'b1;

  logic                 state;
  logic [CFG_W-1:0]     map_columns;
  logic                 awaiting_literal;
  logic [CNT_W-1:0]     pending_count;
  logic [COL_W-1:0]     current_column;
  logic [ROW_W-1:0]     current_row;
  logic                 map_done;
  logic [CNT_W-1:0]     remaining;
  logic [TILE_W-1:0]    tile;

  logic [CFG_W-1:0]     eff_cols;
  logic                 s_acc;
  logic                 m_acc;
  logic [CODE_W-1:0]    code;
  mode_t                mode;

  logic [COL_W-1:0]     start_col;
  logic [ROW_W-1:0]     start_row;
  logic                 done_in;
  logic                 await_in;
  logic [CNT_W-1:0]     pend_in;
  logic                 blocked;
  logic [CNT_W-1:0]     run_len;
  logic [TILE_W-1:0]    run_tile;
  logic                 is_header;

  logic                 col_end;
  logic [COL_W-1:0]     col_inc;
  logic                 complete;
  logic                 last_write;
  logic [ROW_W+OUT_ROW_W-1:0] row_ext;

  assign cfg_ready = 1'b1;
  assign s_tready  = (state == ST_IDLE);
  assign m_tvalid  = (state == ST_RUN);
  assign s_acc     = s_tvalid && s_tready;
  assign m_acc     = m_tvalid && m_tready;
  assign code      = s_tdata;
  assign mode      = code[7:6];

  always_comb begin
    eff_cols = map_columns;
    if (eff_cols == '0) eff_cols = CFG_W'(1);
    if (eff_cols > MAX_COLUMNS) eff_cols = MAX_COLUMNS;
  end

  // position and pending state as seen by this byte
  always_comb begin
    start_col = s_tuser ? '0 : current_column;
    start_row = s_tuser ? '0 : current_row;
    done_in   = s_tuser ? 1'b0 : map_done;
    await_in  = s_tuser ? 1'b0 : awaiting_literal;
    pend_in   = s_tuser ? '0 : pending_count;
    blocked   = ({1'b0, start_col} >= eff_cols);
  end

  always_comb begin
    run_len   = '0;
    run_tile  = '0;
    is_header = 1'b0;
    if (await_in) begin
      run_len  = pend_in;
      run_tile = code;
    end else begin
      unique case (mode)
        MODE_LITERAL: is_header = 1'b1;
        MODE_SHORT: begin
          run_len  = CNT_W'(code[5:4]) + CNT_W'(2);
          run_tile = TILE_W'(code[3:0]) + TILE_W'(1);
        end
        MODE_ZEROS: begin
          run_len  = CNT_W'(code[5:0]);
          run_tile = '0;
        end
        MODE_SINGLE: begin
          run_len  = CNT_W'(1);
          run_tile = TILE_W'(code[5:0]);
        end
        default: is_header = 1'b0;
      endcase
    end
  end

  // row and column stepper, one write per cycle while m_tready is high
  always_comb begin
    col_end    = (current_row == LAST_ROW);
    col_inc    = current_column + COL_W'(1);
    complete   = col_end && (({1'b0, col_inc} >= eff_cols) || (col_inc == '0));
    last_write = col_end || (remaining == CNT_W'(1));
    row_ext    = {{OUT_ROW_W{1'b0}}, current_row};
  end

  assign m_tdata = {tile, row_ext[OUT_ROW_W-1:0], current_column};
  assign m_tlast = last_write;
  assign m_tuser = complete;

  always_ff @(posedge clk) begin
    if (rst) begin
      map_columns <= CFG_W'(1);
    end else if (cfg_valid && cfg_ready) begin
      map_columns <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state            <= ST_IDLE;
      awaiting_literal <= 1'b0;
      pending_count    <= '0;
      current_column   <= '0;
      current_row      <= '0;
      map_done         <= 1'b0;
      remaining        <= '0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (s_acc) begin
            current_column   <= start_col;
            current_row      <= start_row;
            map_done         <= done_in;
            awaiting_literal <= await_in;
            pending_count    <= pend_in;
            if (!done_in) begin
              if (blocked) begin
                map_done         <= 1'b1;
                awaiting_literal <= 1'b0;
                pending_count    <= '0;
              end else if (is_header) begin
                awaiting_literal <= 1'b1;
                pending_count    <= CNT_W'(code[5:0]) + CNT_W'(1);
              end else begin
                awaiting_literal <= 1'b0;
                pending_count    <= '0;
                remaining        <= run_len;
                if (run_len != '0) state <= ST_RUN;
              end
            end
          end
        end
        ST_RUN: begin
          if (m_acc) begin
            remaining <= remaining - CNT_W'(1);
            if (col_end) begin
              current_row    <= '0;
              current_column <= col_inc;
            end else begin
              current_row <= current_row + ROW_W'(1);
            end
            if (complete) map_done <= 1'b1;
            if (last_write) state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (s_acc) tile <= run_tile;
  end

`ifndef SYNTHESIS
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> !s_tready)
    else $error("input taken while writes are pending");

  a_run_nonempty: assert property (@(posedge clk) disable iff (rst)
    state == ST_RUN |-> remaining != '0)
    else $error("run active with no writes left");

  a_last_frees_input: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tready && m_tlast |=> s_tready)
    else $error("input not freed after last write");

  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    map_done |-> state == ST_IDLE)
    else $error("writes after map completion");

  a_complete_is_last: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser |-> m_tlast)
    else $error("map complete on a write that is not last");
`endif

endmodule
